// ===== src/igai_pkg.sv =====
// Shared types and constants for the IMU gyro/accel interpolator.
`default_nettype none

package igai_pkg;

    localparam int AXES   = 3;
    localparam int TIME_W = 64;
    localparam int AXIS_W = 32;
    localparam int CFG_W  = 32;
    localparam int ADDR_W = 3;

    localparam logic [7:0] WARMUP_RESET  = 8'd10;
    localparam logic       PREVIEW_RESET = 1'b1;

    typedef enum logic {
        REG_WARMUP_SAMPLES = 1'b0,
        REG_PREVIEW_MODE   = 1'b1
    } reg_index_t;

    typedef enum logic {
        CMD_GYRO  = 1'b0,
        CMD_ACCEL = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        L_IDLE,
        L_PREP,
        L_MUL_LO,
        L_MUL_HI,
        L_ADD,
        L_DIV,
        L_FIN,
        L_DONE
    } lane_state_t;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } ctrl_state_t;

    // Timestamps handed to each lane: accel time, window start, window end.
    typedef struct packed {
        logic [TIME_W-1:0] ta;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t1;
    } igai_times_t;

    typedef struct packed {
        logic [TIME_W-1:0]             fused_time;
        logic [AXES-1:0][AXIS_W-1:0]   accel;
        logic [AXES-1:0][AXIS_W-1:0]   gyro;
    } igai_result_t;

endpackage

`default_nettype wire

// ===== src/igai_lane.sv =====
// One interpolation lane: g_old + trunc((g_new - g_old) * dt / den), multi-cycle.
`default_nettype none

module igai_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [igai_pkg::AXIS_W-1:0]    g_old,
    input  logic [igai_pkg::AXIS_W-1:0]    g_new,
    input  igai_pkg::igai_times_t          times,
    output logic                           done,
    output logic [igai_pkg::AXIS_W-1:0]    result
);
    import igai_pkg::*;

    lane_state_t state_reg, state_next;
    logic [4:0]  cnt_reg;
    logic        div_last;

    logic [AXIS_W-1:0] g_old_reg, g_new_reg;
    igai_times_t       times_reg;
    logic [TIME_W-1:0] dt_reg, den_reg;
    logic [AXIS_W-1:0] m_reg;
    logic              neg_reg;
    logic [63:0]       plo_reg, phi_reg;
    logic [63:0]       rem_reg;
    logic [31:0]       low_reg;
    logic [31:0]       q_reg;
    logic [AXIS_W-1:0] result_reg;

    logic [AXIS_W:0]   diff;
    logic [AXIS_W:0]   mag;
    logic [64:0]       rem_shift;
    logic [65:0]       rem_sub;
    logic              ge;
    logic [AXIS_W-1:0] q_signed;

    // magnitude of the axis step; always below 2^32
    assign diff = {g_new_reg[AXIS_W-1], g_new_reg} - {g_old_reg[AXIS_W-1], g_old_reg};
    assign mag  = diff[AXIS_W] ? (~diff + {{AXIS_W{1'b0}}, 1'b1}) : diff;

    // restoring divide step; remainder stays below den
    assign rem_shift = {rem_reg, low_reg[31]};
    assign rem_sub   = {1'b0, rem_shift} - {2'b00, den_reg};
    assign ge        = ~rem_sub[65];

    assign q_signed = neg_reg ? (~q_reg + 32'd1) : q_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE, L_DONE:
            begin
                if (start)
                begin
                    state_next = L_PREP;
                end
            end
            L_PREP:   state_next = L_MUL_LO;
            L_MUL_LO: state_next = L_MUL_HI;
            L_MUL_HI: state_next = L_ADD;
            L_ADD:    state_next = L_DIV;
            L_DIV:
            begin
                if (div_last)
                begin
                    state_next = L_FIN;
                end
            end
            L_FIN:    state_next = L_DONE;
            default:  state_next = L_IDLE;
        endcase
    end

    always_comb
    begin
        done     = (state_reg == L_DONE);
        div_last = (state_reg == L_DIV) && (cnt_reg == 5'd31);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == L_ADD)
            begin
                cnt_reg <= 5'd0;
            end
            else if (state_reg == L_DIV)
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            g_old_reg <= g_old;
            g_new_reg <= g_new;
            times_reg <= times;
        end
        case (state_reg)
            L_PREP:
            begin
                dt_reg  <= times_reg.ta - times_reg.t0;
                den_reg <= times_reg.t1 - times_reg.t0;
                m_reg   <= mag[AXIS_W-1:0];
                neg_reg <= diff[AXIS_W];
            end
            L_MUL_LO: plo_reg <= {32'd0, m_reg} * {32'd0, dt_reg[31:0]};
            L_MUL_HI: phi_reg <= {32'd0, m_reg} * {32'd0, dt_reg[63:32]};
            L_ADD:
            begin
                // upper 64 bits of the 96-bit product; below den since dt < den
                rem_reg <= phi_reg + {32'd0, plo_reg[63:32]};
                low_reg <= plo_reg[31:0];
            end
            L_DIV:
            begin
                rem_reg <= ge ? rem_sub[63:0] : rem_shift[63:0];
                low_reg <= {low_reg[30:0], 1'b0};
                q_reg   <= {q_reg[30:0], ge};
            end
            L_FIN:    result_reg <= g_old_reg + q_signed;
            default:
            begin
            end
        endcase
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/igai_merge.sv =====
// Merge stage: packs lane results with the accel sample into the output register.
`default_nettype none

module igai_merge (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           load,
    input  logic [igai_pkg::TIME_W-1:0]                    fused_time,
    input  logic [igai_pkg::AXES-1:0][igai_pkg::AXIS_W-1:0] accel,
    input  logic [igai_pkg::AXES-1:0][igai_pkg::AXIS_W-1:0] gyro,
    input  logic                                           out_ready,
    output logic                                           can_load,
    output logic                                           out_valid,
    output igai_pkg::igai_result_t                         dout
);
    import igai_pkg::*;

    logic         valid_reg, valid_next;
    igai_result_t data_reg;

    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.fused_time <= fused_time;
            data_reg.accel      <= accel;
            data_reg.gyro       <= gyro;
        end
    end

    assign out_valid = valid_reg;
    assign dout      = data_reg;

endmodule

`default_nettype wire

// ===== src/imu_gyro_accel_interpolator.sv =====
// Top level: gyro window, accel latch, warm-up and register file, three lanes and merge.
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+-----------------------------------
//  in      | sink      | in_valid / in_ready           | command, sample_time, sample_x/y/z
//  out     | source    | out_valid / out_ready         | fused_time, accel_x/y/z, gyro_x/y/z
//  cfg     | sink      | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// An accel transaction or a gyro transaction that yields no output is accepted without occupying the lanes.
// A gyro transaction that yields an output occupies the lanes through operand prep,
// two 32x32 partial products, one add, 32 restoring divide steps and a final add.
// in_ready stays low while the lanes run; a finished result waits in the output
// register, and the lanes hold theirs if that register is still full.
// Reset (rst_n, async, active low) clears all control state; no clearing pass.
`default_nettype none

module imu_gyro_accel_interpolator (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [igai_pkg::ADDR_W-1:0]         paddr,
    input  logic [igai_pkg::CFG_W-1:0]          pwdata,
    output logic [igai_pkg::CFG_W-1:0]          prdata,
    output logic                                pready,
    // input transactions
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [igai_pkg::TIME_W-1:0]         sample_time,
    input  logic signed [igai_pkg::AXIS_W-1:0]  sample_x,
    input  logic signed [igai_pkg::AXIS_W-1:0]  sample_y,
    input  logic signed [igai_pkg::AXIS_W-1:0]  sample_z,
    // output transactions
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [igai_pkg::TIME_W-1:0]         fused_time,
    output logic signed [igai_pkg::AXIS_W-1:0]  accel_x,
    output logic signed [igai_pkg::AXIS_W-1:0]  accel_y,
    output logic signed [igai_pkg::AXIS_W-1:0]  accel_z,
    output logic signed [igai_pkg::AXIS_W-1:0]  gyro_x,
    output logic signed [igai_pkg::AXIS_W-1:0]  gyro_y,
    output logic signed [igai_pkg::AXIS_W-1:0]  gyro_z
);
    import igai_pkg::*;

    // configuration registers
    logic [7:0]  warmup_samples_reg;
    logic        preview_mode_reg;
    logic        cfg_write;
    reg_index_t  cfg_index;

    // sample state; only the newer window entry matters, since a shift
    // always makes the old newer entry the older one
    logic [TIME_W-1:0]           win_time_reg;
    logic [AXES-1:0][AXIS_W-1:0] win_axes_reg;
    logic                        primed_reg;
    logic [7:0]                  warmup_cnt_reg;
    logic [TIME_W-1:0]           accel_time_reg;
    logic [AXES-1:0][AXIS_W-1:0] accel_axes_reg;
    logic                        accel_valid_reg;

    ctrl_state_t state_reg, state_next;

    logic [AXES-1:0][AXIS_W-1:0] sample_axes;
    logic        in_fire;
    logic        is_gyro;
    logic        is_newer;
    logic        load_win;
    logic        shift;
    logic        warming;
    logic        in_window;
    logic        launch;
    logic        out_load;

    logic [AXES-1:0]             lane_done;
    logic                        lanes_done;
    logic [AXES-1:0][AXIS_W-1:0] lane_result;
    igai_times_t                 lane_times;

    logic         can_load;
    igai_result_t dout;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        case (cfg_index)
            REG_WARMUP_SAMPLES: prdata = {24'd0, warmup_samples_reg};
            REG_PREVIEW_MODE:   prdata = {31'd0, preview_mode_reg};
            default:            prdata = '0;
        endcase
    end

    // ---------------- input decode ----------------
    assign sample_axes = {sample_z, sample_y, sample_x};
    assign in_fire     = in_valid && in_ready;
    assign is_gyro     = (cmd_t'(command) == CMD_GYRO);
    assign is_newer    = (sample_time > win_time_reg);

    // the first gyro sample primes; later ones must be strictly newer
    assign load_win = in_fire && is_gyro && (!primed_reg || is_newer);
    assign shift    = in_fire && is_gyro && primed_reg && is_newer;
    assign warming  = (warmup_cnt_reg < warmup_samples_reg);

    // accel time within [old newer time, new sample time)
    assign in_window = accel_valid_reg
                    && (accel_time_reg >= win_time_reg)
                    && (accel_time_reg < sample_time);
    assign launch    = shift && !warming && in_window && !preview_mode_reg;

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (launch)
                begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (lanes_done && can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        out_load = (state_reg == S_BUSY) && lanes_done && can_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            warmup_samples_reg <= WARMUP_RESET;
            preview_mode_reg   <= PREVIEW_RESET;
            primed_reg         <= 1'b0;
            warmup_cnt_reg     <= 8'd0;
            accel_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WARMUP_SAMPLES: warmup_samples_reg <= pwdata[7:0];
                    REG_PREVIEW_MODE:   preview_mode_reg   <= pwdata[0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_fire && !is_gyro)
            begin
                accel_valid_reg <= 1'b1;
            end
            if (load_win)
            begin
                primed_reg <= 1'b1;
            end
            if (shift && warming)
            begin
                warmup_cnt_reg <= warmup_cnt_reg + 8'd1;
            end
        end
    end

    // sample payload; read only once the matching flag is set
    always_ff @(posedge clk)
    begin
        if (in_fire && !is_gyro)
        begin
            accel_time_reg <= sample_time;
            accel_axes_reg <= sample_axes;
        end
        if (load_win)
        begin
            win_time_reg <= sample_time;
            win_axes_reg <= sample_axes;
        end
    end

    // ---------------- lanes, one per axis ----------------
    assign lane_times.ta = accel_time_reg;
    assign lane_times.t0 = win_time_reg;
    assign lane_times.t1 = sample_time;

    genvar i;
    generate
        for (i = 0; i < AXES; i++)
        begin : g_lane
            igai_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .start  (launch),
                .g_old  (win_axes_reg[i]),
                .g_new  (sample_axes[i]),
                .times  (lane_times),
                .done   (lane_done[i]),
                .result (lane_result[i])
            );
        end
    endgenerate

    assign lanes_done = &lane_done;

    // ---------------- merge and output register ----------------
    // accel state is frozen while busy, so it pairs with the lane results
    igai_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (out_load),
        .fused_time (accel_time_reg),
        .accel      (accel_axes_reg),
        .gyro       (lane_result),
        .out_ready  (out_ready),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .dout       (dout)
    );

    assign fused_time = dout.fused_time;
    assign accel_x    = dout.accel[0];
    assign accel_y    = dout.accel[1];
    assign accel_z    = dout.accel[2];
    assign gyro_x     = dout.gyro[0];
    assign gyro_y     = dout.gyro[1];
    assign gyro_z     = dout.gyro[2];

    // ---------------- assertions ----------------
    a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        launch |-> (state_reg == S_IDLE))
        else $error("lanes started while busy");

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
        else $error("lanes out of step");

    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_BUSY))
        else $error("output raised without a finished computation");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUSY) |-> !in_fire)
        else $error("transaction accepted while lanes busy");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the IMU gyro/accel interpolator: directed edge cases plus random sensor traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import igai_pkg::*;

    localparam int CLK_PERIOD   = 20;
    // Margin for the slowest gyro transaction to finish before config writes.
    localparam int SETTLE_CYCLES = 64;
    // Watchdog bound on the whole run of ~1500 transactions.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n;

    // APB side
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0]  pwdata;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    // sample input channel
    logic                     in_valid;
    logic                     in_ready;
    logic                     command;
    logic [TIME_W-1:0]        sample_time;
    logic signed [AXIS_W-1:0] sample_x;
    logic signed [AXIS_W-1:0] sample_y;
    logic signed [AXIS_W-1:0] sample_z;

    // fused output channel
    logic                     out_valid;
    logic                     out_ready;
    logic [TIME_W-1:0]        fused_time;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] gyro_x;
    logic signed [AXIS_W-1:0] gyro_y;
    logic signed [AXIS_W-1:0] gyro_z;

    imu_gyro_accel_interpolator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .sample_time (sample_time),
        .sample_x    (sample_x),
        .sample_y    (sample_y),
        .sample_z    (sample_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fused_time  (fused_time),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .gyro_x      (gyro_x),
        .gyro_y      (gyro_y),
        .gyro_z      (gyro_z)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the block's window, accel latch and
    // registers. Updated in transaction order as the input side accepts.
    // ------------------------------------------------------------------
    logic [63:0] win_time [2];          // [0] older, [1] newer
    logic [31:0] win_axes [2][3];
    logic        win_primed;
    logic [7:0]  warm_count;
    logic [63:0] acc_time;
    logic [31:0] acc_axes [3];
    logic        acc_seen;
    logic [7:0]  cfg_warmup;
    logic        cfg_preview;

    igai_result_t pending_fused [$];    // expected fused results, oldest first

    int fail_count   = 0;
    int cycle_count  = 0;
    int n_gyro       = 0;
    int n_accel      = 0;
    int n_stale      = 0;
    int n_fused_seen = 0;

    // idling knobs, flipped during random traffic so there are also bursts
    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;

    // g_old + trunc((g_new - g_old) * dt / span); product kept at full width
    function automatic logic [31:0] interp_axis(logic [31:0] g_old, logic [31:0] g_new,
                                                logic [63:0] dt, logic [63:0] span);
        logic signed [63:0] base;
        logic signed [63:0] diff;
        logic signed [63:0] delta;
        logic signed [63:0] sum;
        logic [127:0]       prod;
        logic [127:0]       quo;
        base  = {{32{g_old[31]}}, g_old};
        diff  = {{32{g_new[31]}}, g_new} - base;
        prod  = diff[63] ? -diff : diff;
        prod  = prod * dt;
        quo   = prod / span;
        delta = quo[63:0];
        if (diff[63])
            delta = -delta;
        sum = base + delta;
        return sum[31:0];
    endfunction

    // Advance the shadow state by one accepted transaction; returns 1 when a
    // fused result is due, with its contents in res.
    function automatic bit predict_sample(input cmd_t cmd, input logic [63:0] t,
                                          input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, output igai_result_t res);
        logic [31:0] s [3];
        s[0] = x;
        s[1] = y;
        s[2] = z;
        res  = '0;
        if (cmd == CMD_ACCEL) begin
            n_accel++;
            acc_time = t;
            for (int i = 0; i < AXES; i++)
                acc_axes[i] = s[i];
            acc_seen = 1'b1;
            return 1'b0;
        end
        n_gyro++;
        if (!win_primed) begin
            win_time[0] = t;
            win_time[1] = t;
            for (int i = 0; i < AXES; i++) begin
                win_axes[0][i] = s[i];
                win_axes[1][i] = s[i];
            end
            win_primed = 1'b1;
            return 1'b0;
        end
        if (t <= win_time[1]) begin
            n_stale++;
            return 1'b0;
        end
        win_time[0] = win_time[1];
        win_time[1] = t;
        for (int i = 0; i < AXES; i++) begin
            win_axes[0][i] = win_axes[1][i];
            win_axes[1][i] = s[i];
        end
        if (warm_count < cfg_warmup) begin
            warm_count++;
            return 1'b0;
        end
        if (!acc_seen || acc_time < win_time[0] || acc_time >= win_time[1] || cfg_preview)
            return 1'b0;
        res.fused_time = acc_time;
        for (int i = 0; i < AXES; i++) begin
            res.accel[i] = acc_axes[i];
            res.gyro[i]  = interp_axis(win_axes[0][i], win_axes[1][i],
                                       acc_time - win_time[0], win_time[1] - win_time[0]);
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one transaction, random lead-in gap, valid held until
    // accepted. Changes on the falling edge, handshake seen on the rising.
    // ------------------------------------------------------------------
    task automatic send_sample(cmd_t cmd, logic [63:0] t,
                               logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int           gap;
        igai_result_t res;
        gap = in_idle_on ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        sample_time <= t;
        sample_x    <= x;
        sample_y    <= y;
        sample_z    <= z;
        do @(posedge clk); while (!in_ready);
        if (predict_sample(cmd, t, x, y, z, res))
            pending_fused = {pending_fused, res};
    endtask

    // Hold off the sender until every expected result is out, then let the
    // lanes settle (a suppressed gyro transaction leaves nothing to wait on).
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_fused.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write then read-back; only ever called with the block idle.
    task automatic write_reg(reg_index_t idx, logic [31:0] data);
        logic [ADDR_W-1:0] addr;
        logic [31:0]       readback;
        logic [31:0]       stored;
        drain_pipeline();
        addr = idx;
        addr = addr << 2;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_WARMUP_SAMPLES)
            cfg_warmup = data[7:0];
        else
            cfg_preview = data[0];
        // back-to-back read of the same register, psel kept high
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        stored = (idx == REG_WARMUP_SAMPLES) ? {24'd0, cfg_warmup} : {31'd0, cfg_preview};
        if (readback !== stored) begin
            $error("register %s read-back: expected %h, actual %h", idx.name(), stored, readback);
            fail_count++;
        end
    endtask

    function automatic logic [31:0] rand_axis();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // gyro period: mostly short, sometimes 32-bit, rarely ~40-bit
    function automatic logic [63:0] rand_step();
        logic [63:0] s;
        case ($urandom_range(0, 19))
            0, 1: s = 64'd1;
            2: begin
                s = $urandom_range(1, 255);
                s = (s << 32) | $urandom;
            end
            3, 4, 5, 6, 7: begin
                s = $urandom;
                s = s + 64'd1;
            end
            default: s = $urandom_range(2, 5000);
        endcase
        return s;
    endfunction

    // offset into [0, step), leaning on both ends of the window
    function automatic logic [63:0] pick_offset(logic [63:0] step);
        case ($urandom_range(0, 3))
            0:       return 64'd0;
            1:       return step - 64'd1;
            default: return {$urandom, $urandom} % step;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall before each result while idling is on, and the checker.
    // ------------------------------------------------------------------
    initial begin : drive_out_ready
        int stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever begin
            stall = out_idle_on ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk) begin : check_results
        igai_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_fused.size() == 0) begin
                $error("fused transaction with nothing expected (time %h)", fused_time);
                fail_count++;
            end else begin
                want = pending_fused.pop_front();
                n_fused_seen++;
                check_field("fused_time", want.fused_time, fused_time);
                check_field("accel_x", want.accel[0], $unsigned(accel_x));
                check_field("accel_y", want.accel[1], $unsigned(accel_y));
                check_field("accel_z", want.accel[2], $unsigned(accel_z));
                check_field("gyro_x", want.gyro[0], $unsigned(gyro_x));
                check_field("gyro_y", want.gyro[1], $unsigned(gyro_y));
                check_field("gyro_z", want.gyro[2], $unsigned(gyro_z));
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("watchdog expired with %0d results outstanding", pending_fused.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Junk in the upper register bits; priming, warm-up of 2, then a gyro
    // shift with warm-up done but no accel seen yet -> nothing out.
    task automatic test_config_and_priming();
        write_reg(REG_WARMUP_SAMPLES, 32'hABCD_EF02);
        write_reg(REG_PREVIEW_MODE, 32'hFFFF_FFFE);
        send_sample(CMD_GYRO, 64'd0,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_sample(CMD_GYRO, 64'd10, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678);
        send_sample(CMD_GYRO, 64'd20, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_sample(CMD_GYRO, 64'd30, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    endtask

    // accel on the lower edge (hit, dt = 0), on the upper edge (miss),
    // below the window (miss), and one tick under the upper edge (hit)
    task automatic test_window_edges();
        send_sample(CMD_ACCEL, 64'd30, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_sample(CMD_GYRO,  64'd40, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_sample(CMD_ACCEL, 64'd50, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_sample(CMD_GYRO,  64'd50, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_sample(CMD_ACCEL, 64'd39, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
        send_sample(CMD_GYRO,  64'd60, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_sample(CMD_ACCEL, 64'd69, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        send_sample(CMD_GYRO,  64'd70, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    endtask

    // gyro equal to and older than the newest entry is dropped; window intact
    task automatic test_stale_gyro();
        send_sample(CMD_ACCEL, 64'd75, 32'h0000_1000, 32'hFFFF_F000, 32'h7FFF_FFFF);
        send_sample(CMD_GYRO,  64'd70, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
        send_sample(CMD_GYRO,  64'd3,  32'h4444_4444, 32'h5555_5555, 32'h6666_6666);
        send_sample(CMD_GYRO,  64'd80, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    endtask

    // preview suppresses a hit but the window keeps moving
    task automatic test_preview_mode();
        write_reg(REG_PREVIEW_MODE, 32'h0000_0001);
        send_sample(CMD_ACCEL, 64'd85, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004);
        send_sample(CMD_GYRO,  64'd90, 32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0000);
        write_reg(REG_PREVIEW_MODE, 32'h0000_0000);
        send_sample(CMD_ACCEL, 64'd91, 32'hCAFE_0000, 32'h0000_BEEF, 32'h8000_0001);
        send_sample(CMD_GYRO,  64'd100, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0100);
    endtask

    // warm-up register dropped below the count already reached
    task automatic test_lowered_warmup();
        write_reg(REG_WARMUP_SAMPLES, 32'h0000_0001);
        send_sample(CMD_ACCEL, 64'd100, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_sample(CMD_GYRO,  64'd110, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
    endtask

    // Mostly well-formed (accel inside the coming window, then the gyro that
    // closes it), the rest stale gyro, out-of-window or arbitrary accel.
    task automatic test_random_traffic(logic [7:0] warmup, logic preview, int n_items);
        int          sent;
        logic [31:0] junk;
        logic [63:0] step;
        junk = $urandom;
        write_reg(REG_WARMUP_SAMPLES, {junk[31:8], warmup});
        write_reg(REG_PREVIEW_MODE, {junk[31:1], preview});
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 29) == 0) begin
                in_idle_on  = $urandom_range(0, 1);
                out_idle_on = $urandom_range(0, 1);
            end
            step = rand_step();
            case ($urandom_range(0, 9))
                7: begin
                    // not newer than the newest entry: ignored by the block
                    send_sample(CMD_GYRO,
                                win_time[1] - (win_time[1] > 64 ? $urandom_range(0, 64) : 0),
                                rand_axis(), rand_axis(), rand_axis());
                    sent++;
                end
                8: begin
                    send_sample(CMD_ACCEL, {$urandom, $urandom},
                                rand_axis(), rand_axis(), rand_axis());
                    send_sample(CMD_GYRO, win_time[1] + step,
                                rand_axis(), rand_axis(), rand_axis());
                    sent += 2;
                end
                9: begin
                    // accel just past either end of the coming window
                    send_sample(CMD_ACCEL,
                                $urandom_range(0, 1) ? win_time[1] + step : win_time[1] - 1,
                                rand_axis(), rand_axis(), rand_axis());
                    send_sample(CMD_GYRO, win_time[1] + step,
                                rand_axis(), rand_axis(), rand_axis());
                    sent += 2;
                end
                default: begin
                    // an earlier accel in the same window gets overwritten
                    if ($urandom_range(0, 3) == 0) begin
                        send_sample(CMD_ACCEL, win_time[1] + pick_offset(step),
                                    rand_axis(), rand_axis(), rand_axis());
                        sent++;
                    end
                    send_sample(CMD_ACCEL, win_time[1] + pick_offset(step),
                                rand_axis(), rand_axis(), rand_axis());
                    send_sample(CMD_GYRO, win_time[1] + step,
                                rand_axis(), rand_axis(), rand_axis());
                    sent += 2;
                end
            endcase
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // Runs last: timestamps are monotonic, so after the all-ones time every
    // further gyro transaction would be dropped. Huge span -> 96-bit product.
    task automatic test_time_limits();
        send_sample(CMD_GYRO,  win_time[1] + 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_sample(CMD_ACCEL, 64'hC000_0000_1234_5678,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_sample(CMD_GYRO,  TIME_MAX, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_sample(CMD_ACCEL, TIME_MAX, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
        send_sample(CMD_GYRO,  TIME_MAX, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        command     = CMD_GYRO;
        sample_time = '0;
        sample_x    = '0;
        sample_y    = '0;
        sample_z    = '0;

        // shadow state at reset
        win_time[0] = '0;
        win_time[1] = '0;
        for (int i = 0; i < AXES; i++) begin
            win_axes[0][i] = '0;
            win_axes[1][i] = '0;
            acc_axes[i]    = '0;
        end
        win_primed  = 1'b0;
        warm_count  = '0;
        acc_time    = '0;
        acc_seen    = 1'b0;
        cfg_warmup  = WARMUP_RESET;
        cfg_preview = PREVIEW_RESET;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_config_and_priming();
        test_window_edges();
        test_stale_gyro();
        test_preview_mode();
        test_lowered_warmup();
        test_random_traffic(8'd0,   1'b0, 450);
        test_random_traffic(8'd0,   1'b1, 100);
        test_random_traffic(8'd40,  1'b0, 250);
        test_random_traffic(8'd255, 1'b0, 400);
        test_random_traffic(8'd128, 1'b0, 200);
        test_time_limits();

        drain_pipeline();
        $display("tb_top: %0d gyro and %0d accel transactions sent, %0d stale gyro dropped",
                 n_gyro, n_accel, n_stale);
        $display("tb_top: %0d fused results checked across warm-up 0..255 and preview on/off",
                 n_fused_seen);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
